// ===== design/trs_model_matrix_defines.svh =====
// ----------------------------------------------------------------------------
// trs_model_matrix assertion macros
// shared assertion helpers for the model matrix pipeline
// ----------------------------------------------------------------------------
`ifndef TRS_MODEL_MATRIX_DEFINES_SVH
`define TRS_MODEL_MATRIX_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define TRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_pkg
// constants and types for the model matrix pipeline
// ----------------------------------------------------------------------------
package trs_pkg;
    localparam int ATAN_COUNT = 24;
    localparam logic signed [63:0] ONE_Q28     = 64'sd268435456;
    localparam logic signed [63:0] PI_Q28      = 64'sd843314857;
    localparam logic signed [63:0] TWO_PI_Q28  = 64'sd1686629714;
    localparam logic signed [63:0] HALF_PI_Q28 = 64'sd421657428;
    localparam logic signed [63:0] GAIN_Q28    = 64'sd163008218;

    // arc tangent of 2^-i in q.28
    function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:  v = 32'sd210828714;
            5'd1:  v = 32'sd124459457;
            5'd2:  v = 32'sd65760959;
            5'd3:  v = 32'sd33381290;
            5'd4:  v = 32'sd16755422;
            5'd5:  v = 32'sd8385879;
            5'd6:  v = 32'sd4193963;
            5'd7:  v = 32'sd2097109;
            5'd8:  v = 32'sd1048571;
            5'd9:  v = 32'sd524287;
            5'd10: v = 32'sd262144;
            5'd11: v = 32'sd131072;
            5'd12: v = 32'sd65536;
            5'd13: v = 32'sd32768;
            5'd14: v = 32'sd16384;
            5'd15: v = 32'sd8192;
            5'd16: v = 32'sd4096;
            5'd17: v = 32'sd2048;
            5'd18: v = 32'sd1024;
            5'd19: v = 32'sd512;
            5'd20: v = 32'sd256;
            5'd21: v = 32'sd128;
            5'd22: v = 32'sd64;
            5'd23: v = 32'sd32;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // payload carried alongside the cordic stages
    typedef struct packed {
        logic signed [31:0] move_x, move_y, move_z;
        logic signed [15:0] axis_x, axis_y, axis_z;
        logic signed [31:0] stretch_x, stretch_y, stretch_z;
    } t_side;

    // one cordic stage state
    typedef struct packed {
        logic               flip;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_rot;
endpackage

// ===== design/trs_model_matrix.sv =====
// ----------------------------------------------------------------------------
// trs_model_matrix
// pipelined model matrix builder: translation, axis-angle rotation and scale
// ----------------------------------------------------------------------------
//  channel   | dir | tdata fields (low bit first)
//  s_axis    | in  | move_x move_y move_z turn_angle axis_x axis_y axis_z stretch_x ... (256 bits)
//  m_axis    | out | m00 m01 m02 m03 m10 m11 m12 m13 m20 m21 m22 m23 (384 bits)
//
//  one transfer per cycle in and out while the output is not stalled. STEPS
//  is CORDIC_STEPS capped at 24; the pipeline has one reduction stage, STEPS
//  unrolled cordic stages and five stages for rodrigues terms, scaling and
//  output. the whole pipeline advances when the output stage is empty or
//  taken, so a stall freezes every stage. reset (synchronous, active low)
//  clears the valid bits only.
// ----------------------------------------------------------------------------
`include "trs_model_matrix_defines.svh"

module trs_model_matrix #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // move_x, move_y, move_z, turn_angle, axis_x, axis_y, axis_z,
    // stretch_x, stretch_y, stretch_z
    input  logic [255:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // m00 m01 m02 m03 m10 m11 m12 m13 m20 m21 m22 m23
    output logic [383:0] m_axis_tdata
);
    localparam int STEPS = (CORDIC_STEPS > trs_pkg::ATAN_COUNT) ?
                           trs_pkg::ATAN_COUNT : CORDIC_STEPS;
    // stages: 0 reduce, 1..STEPS cordic, then 5 matrix stages
    localparam int DEPTH = STEPS + 6;

    logic adv;
    logic [DEPTH-1:0] r_vld;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // input unpacking
    trs_pkg::t_side in_side;
    logic signed [15:0] in_angle;
    assign in_side.move_x    = s_axis_tdata[31:0];
    assign in_side.move_y    = s_axis_tdata[63:32];
    assign in_side.move_z    = s_axis_tdata[95:64];
    assign in_angle          = s_axis_tdata[111:96];
    assign in_side.axis_x    = s_axis_tdata[127:112];
    assign in_side.axis_y    = s_axis_tdata[143:128];
    assign in_side.axis_z    = s_axis_tdata[159:144];
    assign in_side.stretch_x = s_axis_tdata[191:160];
    assign in_side.stretch_y = s_axis_tdata[223:192];
    assign in_side.stretch_z = s_axis_tdata[255:224];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
        end
    end

    // ---- stage 0: angle reduction into [-pi/2, pi/2]
    logic signed [63:0] red_a;
    logic               red_flip;
    always_comb begin
        red_a = 64'(in_angle) <<< 16;
        red_flip = 1'b0;
        if (red_a >= trs_pkg::PI_Q28) begin
            red_a = red_a - trs_pkg::TWO_PI_Q28;
        end else if (red_a < -trs_pkg::PI_Q28) begin
            red_a = red_a + trs_pkg::TWO_PI_Q28;
        end
        if (red_a > trs_pkg::HALF_PI_Q28) begin
            red_a = red_a - trs_pkg::PI_Q28;
            red_flip = 1'b1;
        end else if (red_a < -trs_pkg::HALF_PI_Q28) begin
            red_a = red_a + trs_pkg::PI_Q28;
            red_flip = 1'b1;
        end
    end

    trs_pkg::t_rot  r_rot  [STEPS+1];
    trs_pkg::t_side r_side [STEPS+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rot[0].flip <= red_flip;
            r_rot[0].x    <= 32'(trs_pkg::GAIN_Q28);
            r_rot[0].y    <= '0;
            r_rot[0].z    <= 32'(red_a);
            r_side[0]     <= in_side;
        end
    end

    // ---- cordic stages, one micro-rotation each
    for (genvar g = 0; g < STEPS; g++) begin : g_cordic
        trs_pkg::t_rot n_rot;
        always_comb begin
            n_rot = r_rot[g];
            if (!r_rot[g].z[31]) begin
                n_rot.x = r_rot[g].x - (r_rot[g].y >>> g);
                n_rot.y = r_rot[g].y + (r_rot[g].x >>> g);
                n_rot.z = r_rot[g].z - trs_pkg::atan_q28(5'(g));
            end else begin
                n_rot.x = r_rot[g].x + (r_rot[g].y >>> g);
                n_rot.y = r_rot[g].y - (r_rot[g].x >>> g);
                n_rot.z = r_rot[g].z + trs_pkg::atan_q28(5'(g));
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rot[g+1]  <= n_rot;
                r_side[g+1] <= r_side[g];
            end
        end
    end

    // ---- stage A: cos, sin, 1-cos and axis products
    trs_pkg::t_side     r_sa;
    logic signed [31:0] r_c, r_s, r_omc;
    logic signed [31:0] r_pp [3][3];  // axis_i * axis_j
    logic signed [15:0] ax [3];
    logic signed [31:0] fc, fs;
    assign ax[0] = r_side[STEPS].axis_x;
    assign ax[1] = r_side[STEPS].axis_y;
    assign ax[2] = r_side[STEPS].axis_z;
    assign fc = r_rot[STEPS].flip ? -r_rot[STEPS].x : r_rot[STEPS].x;
    assign fs = r_rot[STEPS].flip ? -r_rot[STEPS].y : r_rot[STEPS].y;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sa  <= r_side[STEPS];
            r_c   <= fc;
            r_s   <= fs;
            r_omc <= 32'(trs_pkg::ONE_Q28) - fc;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pp[i][j] <= ax[i] * ax[j];
                end
            end
        end
    end

    // ---- stage B: rodrigues products
    trs_pkg::t_side     r_sb;
    logic signed [31:0] r_cb;
    logic signed [63:0] r_p [3][3];   // pp * (1-c) >> 28
    logic signed [47:0] r_as [3];     // axis * s >> 14
    logic signed [15:0] axa [3];
    assign axa[0] = r_sa.axis_x;
    assign axa[1] = r_sa.axis_y;
    assign axa[2] = r_sa.axis_z;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sb <= r_sa;
            r_cb <= r_c;
            for (int i = 0; i < 3; i++) begin
                r_as[i] <= 48'((64'(axa[i]) * 64'(r_s)) >>> 14);
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= (64'(r_pp[i][j]) * 64'(r_omc)) >>> 28;
                end
            end
        end
    end

    // ---- stage C: rotation entries
    trs_pkg::t_side     r_sc;
    logic signed [63:0] r_r [3][3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sc <= r_sb;
            r_r[0][0] <= 64'(r_cb) + r_p[0][0];
            r_r[0][1] <= r_p[0][1] - 64'(r_as[2]);
            r_r[0][2] <= r_p[0][2] + 64'(r_as[1]);
            r_r[1][0] <= r_p[1][0] + 64'(r_as[2]);
            r_r[1][1] <= 64'(r_cb) + r_p[1][1];
            r_r[1][2] <= r_p[1][2] - 64'(r_as[0]);
            r_r[2][0] <= r_p[2][0] - 64'(r_as[1]);
            r_r[2][1] <= r_p[2][1] + 64'(r_as[0]);
            r_r[2][2] <= 64'(r_cb) + r_p[2][2];
        end
    end

    // ---- stage D: magnitudes; stage E: product, round, saturate
    // a rotation entry stays below 2^31 + 2^30 in magnitude, so 32 bits hold it
    trs_pkg::t_side r_sd;
    logic [31:0] r_ra [3][3];
    logic [31:0] r_ka [3];
    logic        r_ng [3][3];
    logic signed [31:0] stc [3];
    assign stc[0] = r_sc.stretch_x;
    assign stc[1] = r_sc.stretch_y;
    assign stc[2] = r_sc.stretch_z;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sd <= r_sc;
            for (int j = 0; j < 3; j++) begin
                r_ka[j] <= stc[j][31] ? 32'(-stc[j]) : 32'(stc[j]);
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_ra[i][j] <= r_r[i][j][63] ? 32'(-r_r[i][j]) : 32'(r_r[i][j]);
                    r_ng[i][j] <= r_r[i][j][63] != stc[j][31];
                end
            end
        end
    end

    logic [31:0] n_m [3][3];
    always_comb begin
        logic [63:0] q;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                q = (64'(r_ra[i][j]) * 64'(r_ka[j]) + 64'd134217728) >> 28;
                if (r_ng[i][j]) begin
                    n_m[i][j] = (q > 64'd2147483648) ? 32'h8000_0000 : 32'(-q);
                end else begin
                    n_m[i][j] = (q > 64'd2147483647) ? 32'h7fff_ffff : q[31:0];
                end
            end
        end
    end

    logic [383:0] r_out;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= {r_sd.move_z, n_m[2][2], n_m[2][1], n_m[2][0],
                      r_sd.move_y, n_m[1][2], n_m[1][1], n_m[1][0],
                      r_sd.move_x, n_m[0][2], n_m[0][1], n_m[0][0]};
        end
    end

    assign m_axis_tvalid = r_vld[DEPTH-1];
    assign m_axis_tdata  = r_out;

    `TRS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output changed during stall")
    `TRS_ASSERT_IMPL(a_ready_rule, i_clk, i_rst_n, !m_axis_tvalid,
        s_axis_tready, "input stalled with empty output")
    `TRS_ASSERT_NEXT(a_freeze, i_clk, i_rst_n, !adv,
        r_vld == $past(r_vld), "pipeline moved while stalled")
endmodule
